>>> hdl/ansp_pkg.sv
// Shared types, constants and helpers for the Annex-B NAL unit splitter.
package ansp_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [OFFSET_BITS-1:0] t_off;

    localparam t_off POS_MAX   = {OFFSET_BITS{1'b1}};
    localparam t_off POS_ONE   = t_off'(1);
    localparam t_off POS_TWO   = t_off'(2);
    localparam t_off POS_THREE = t_off'(3);

    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [7:0] START_CODE_BYTE = 8'h01;

    localparam logic [2:0] SC_SIZE_NONE  = 3'd0;
    localparam logic [2:0] SC_SIZE_SHORT = 3'd3;
    localparam logic [2:0] SC_SIZE_LONG  = 3'd4;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_END    = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_UNITS = 1'b1;

    typedef struct packed {
        logic        rec_valid;
        logic [31:0] code_offset;
        logic [2:0]  code_size;
        logic [31:0] nal_offset;
        logic [31:0] nal_size;
        logic        end_valid;
        logic        status;
    } t_evt;

    function automatic logic [31:0] to_u32(input t_off v);
        logic [OFFSET_BITS+31:0] wide;
        wide = {32'b0, v};
        return wide[31:0];
    endfunction

    function automatic t_off sat_inc(input t_off v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

endpackage

>>> hdl/annexb_nal_unit_splitter.sv
// Annex-B start code NAL unit splitter, top level.
//
//  channel  direction  handshake      payload
//  input    in         i_push/o_full  i_data_byte, i_end_of_stream
//  result   out        o_empty/i_pop  o_kind, o_start_code_offset, o_start_code_size,
//                                     o_nal_offset, o_nal_size, o_status, o_last_of_run
//
// One byte is accepted per cycle while full is low; the scanner classifies it in the cycle it arrives.
// Each byte yields zero, one or two results; results leave one per cycle while pop is held from a
// four-entry event queue, so full rises only while results back up behind pop.
// A result is registered in the event queue when its byte is accepted and is visible once earlier results are popped.
// Synchronous active-low reset clears position, window, unit state and the queue.
module annexb_nal_unit_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_kind,
    output logic [31:0] o_start_code_offset,
    output logic [2:0]  o_start_code_size,
    output logic [31:0] o_nal_offset,
    output logic [31:0] o_nal_size,
    output logic        o_status,
    output logic        o_last_of_run
);
    import ansp_pkg::*;

    logic evt_valid;
    t_evt evt;
    t_evt head;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_full = q_full;

    ansp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (q_full),
        .o_evt_valid     (evt_valid),
        .o_evt           (evt)
    );

    ansp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_valid),
        .i_evt   (evt),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    ansp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_empty           (q_empty),
        .i_head              (head),
        .o_q_pop             (q_pop),
        .o_empty             (o_empty),
        .i_pop               (i_pop),
        .o_kind              (o_kind),
        .o_start_code_offset (o_start_code_offset),
        .o_start_code_size   (o_start_code_size),
        .o_nal_offset        (o_nal_offset),
        .o_nal_size          (o_nal_size),
        .o_status            (o_status),
        .o_last_of_run       (o_last_of_run)
    );

endmodule

>>> hdl/ansp_front.sv
// Byte scanner: detects start codes and builds unit records and end events.
module ansp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_stream,
    input  logic          i_q_full,
    output logic          o_evt_valid,
    output ansp_pkg::t_evt o_evt
);
    import ansp_pkg::*;

    logic [23:0] r_window, n_window;
    t_off        r_pos, n_pos;
    logic        r_open, n_open;
    t_off        r_code_off, n_code_off;
    logic [2:0]  r_code_size, n_code_size;
    t_off        r_pay_off, n_pay_off;
    logic        r_found, n_found;

    logic        accept;
    logic        start;
    logic        four;
    t_off        code;
    t_off        pos_next;
    t_off        close_end;
    logic        rec_valid;
    t_off        rec_size;

    assign accept    = i_push && !i_q_full;
    assign pos_next  = sat_inc(r_pos);
    assign start     = (i_data_byte == START_CODE_BYTE) && (r_pos >= POS_TWO)
                       && (r_window[15:0] == 16'h0000);
    assign four      = (r_pos >= POS_THREE) && (r_window[23:16] == BYTE_ZERO);
    assign code      = four ? r_pos - POS_THREE : r_pos - POS_TWO;
    assign close_end = start ? code : pos_next;
    assign rec_valid = r_open && (start || i_end_of_stream) && (close_end > r_pay_off);
    assign rec_size  = close_end - r_pay_off;

    always_comb begin
        o_evt_valid       = accept && (rec_valid || i_end_of_stream);
        o_evt.rec_valid   = rec_valid;
        o_evt.code_offset = to_u32(r_code_off);
        o_evt.code_size   = r_code_size;
        o_evt.nal_offset  = to_u32(r_pay_off);
        o_evt.nal_size    = to_u32(rec_size);
        o_evt.end_valid   = i_end_of_stream;
        o_evt.status      = (r_found || rec_valid) ? STATUS_OK : STATUS_NO_UNITS;
    end

    always_comb begin
        n_window    = r_window;
        n_pos       = r_pos;
        n_open      = r_open;
        n_code_off  = r_code_off;
        n_code_size = r_code_size;
        n_pay_off   = r_pay_off;
        n_found     = r_found;
        if (accept) begin
            if (i_end_of_stream) begin
                n_window    = '0;
                n_pos       = '0;
                n_open      = 1'b0;
                n_code_off  = '0;
                n_code_size = SC_SIZE_NONE;
                n_pay_off   = '0;
                n_found     = 1'b0;
            end else begin
                n_window = {r_window[15:0], i_data_byte};
                n_pos    = pos_next;
                n_found  = r_found || rec_valid;
                if (start) begin
                    n_open      = 1'b1;
                    n_code_off  = code;
                    n_code_size = four ? SC_SIZE_LONG : SC_SIZE_SHORT;
                    n_pay_off   = pos_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_pos       <= '0;
            r_open      <= 1'b0;
            r_code_off  <= '0;
            r_code_size <= SC_SIZE_NONE;
            r_pay_off   <= '0;
            r_found     <= 1'b0;
        end else begin
            r_window    <= n_window;
            r_pos       <= n_pos;
            r_open      <= n_open;
            r_code_off  <= n_code_off;
            r_code_size <= n_code_size;
            r_pay_off   <= n_pay_off;
            r_found     <= n_found;
        end
    end

    a_rec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_valid && o_evt.rec_valid) |-> (o_evt.nal_size != 32'd0))
        else $error("empty unit reported");

    a_open_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_code_size == SC_SIZE_SHORT || r_code_size == SC_SIZE_LONG))
        else $error("open unit without valid start code size");

endmodule

>>> hdl/ansp_queue.sv
// Short event queue between the scanner and the result serialiser.
module ansp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ansp_pkg::t_evt i_evt,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ansp_pkg::t_evt o_head
);
    import ansp_pkg::*;

    t_evt                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, n_wr;
    logic [QUEUE_AW-1:0] r_rd, n_rd;
    logic [QUEUE_AW:0]   r_cnt, n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");

endmodule

>>> hdl/ansp_back.sv
// Result serialiser: turns each queued event into one or two result transfers.
module ansp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ansp_pkg::t_evt i_head,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_kind,
    output logic [31:0]    o_start_code_offset,
    output logic [2:0]     o_start_code_size,
    output logic [31:0]    o_nal_offset,
    output logic [31:0]    o_nal_size,
    output logic           o_status,
    output logic           o_last_of_run
);
    import ansp_pkg::*;

    logic r_rec_done, n_rec_done;
    logic show_rec;
    logic take;

    assign o_empty  = i_q_empty;
    assign show_rec = i_head.rec_valid && !r_rec_done;
    assign take     = i_pop && !i_q_empty;
    assign o_q_pop  = take && !(show_rec && i_head.end_valid);

    always_comb begin
        if (show_rec) begin
            o_kind              = KIND_RECORD;
            o_start_code_offset = i_head.code_offset;
            o_start_code_size   = i_head.code_size;
            o_nal_offset        = i_head.nal_offset;
            o_nal_size          = i_head.nal_size;
            o_status            = STATUS_OK;
            o_last_of_run       = !i_head.end_valid;
        end else begin
            o_kind              = KIND_END;
            o_start_code_offset = 32'd0;
            o_start_code_size   = SC_SIZE_NONE;
            o_nal_offset        = 32'd0;
            o_nal_size          = 32'd0;
            o_status            = i_head.status;
            o_last_of_run       = 1'b1;
        end
    end

    always_comb begin
        n_rec_done = r_rec_done;
        if (o_q_pop) begin
            n_rec_done = 1'b0;
        end else if (take) begin
            n_rec_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_done <= 1'b0;
        end else begin
            r_rec_done <= n_rec_done;
        end
    end

    a_done_has_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_done |-> (!i_q_empty && i_head.end_valid && i_head.rec_valid))
        else $error("record marked sent without a pending end item");

endmodule
